[hw/rtl/fpt_pkg.sv]
// Shared types and constants for the fault priority table.
`timescale 1ns / 1ps

package fpt_pkg;

    // Operation codes carried on i_operation
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Level that is never selected by a peek
    localparam logic [7:0] NEVER_LEVEL = 8'hff;

    // One stored fault report
    typedef struct packed {
        logic [7:0]  board;
        logic [15:0] code;
        logic [7:0]  level;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[hw/rtl/fpt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module fpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/fault_priority_table.sv]
// Fault priority table: top level with slot memory and scan sequencer.
`timescale 1ns / 1ps

// A table of SLOTS fault reports (board id, error code, level) held in one
// synchronous RAM. Every request is a linear scan of that RAM, one slot per
// cycle: insert stops at the first empty slot (error code zero), remove stops
// at the first slot matching board id and error code, peek walks all slots and
// returns the lowest-level non-empty slot, lowest index on ties, never level
// 255. A request is taken when start is high and busy is low; its result shows
// on the o_ ports with o_valid high for exactly one cycle, and the receiver
// cannot stall it. A scan reads at most SLOTS slots, always SLOTS for peek;
// operation 3 answers with all zero fields in the cycle after accept. busy
// drops while the result is shown, so the next request can be taken at the
// edge that takes the result. The single RAM read port sets the scan rate.
// Per-slot valid flops cleared by reset make the table empty at once; no
// clearing pass is needed.
module fault_priority_table #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_board_id,
    input  logic [15:0] i_error_code,
    input  logic [7:0]  i_level,
    output logic        o_valid,
    output logic        o_ok,
    output logic [7:0]  o_top_board_id,
    output logic [15:0] o_top_error_code,
    output logic [7:0]  o_top_level
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_SCAN = 1'b1;

    logic [0:0]       r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [1:0]       r_op;
    fpt_pkg::t_entry  r_req;
    fpt_pkg::t_entry  r_best, n_best;
    logic             r_found, n_found;
    logic [7:0]       r_best_lvl, n_best_lvl;

    logic             r_out_valid, n_out_valid;
    logic             r_out_ok, n_out_ok;
    fpt_pkg::t_entry  r_out, n_out;

    logic                         ram_we;
    logic [fpt_pkg::ENTRY_W-1:0]  ram_q;
    fpt_pkg::t_entry              slot;
    logic                         accept;
    logic                         last;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign last   = (r_idx == LAST_IDX);

    // slot memory; an entry whose valid bit is clear reads as all zero
    fpt_ram #(
        .WIDTH (fpt_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_req),
        .i_raddr (n_idx),
        .o_rdata (ram_q)
    );

    assign slot = r_valid[r_idx] ? fpt_pkg::t_entry'(ram_q) : fpt_pkg::t_entry'('0);

    // scan sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_valid     = r_valid;
        n_best      = r_best;
        n_found     = r_found;
        n_best_lvl  = r_best_lvl;
        n_out_valid = 1'b0;
        n_out_ok    = r_out_ok;
        n_out       = r_out;
        ram_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_idx      = '0;
                n_best     = '0;
                n_found    = 1'b0;
                n_best_lvl = fpt_pkg::NEVER_LEVEL;
                if (accept) begin
                    if (i_operation == fpt_pkg::OP_NONE) begin
                        n_out_valid = 1'b1;
                        n_out_ok    = 1'b0;
                        n_out       = '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_idx = r_idx + IW'(1);
                case (r_op)
                    fpt_pkg::OP_INSERT: begin
                        if (slot.code == '0) begin
                            ram_we           = 1'b1;
                            n_valid[r_idx]   = 1'b1;
                            n_state          = S_IDLE;
                            n_out_valid      = 1'b1;
                            n_out_ok         = 1'b1;
                            n_out            = '0;
                        end else if (last) begin
                            n_state     = S_IDLE;
                            n_out_valid = 1'b1;
                            n_out_ok    = 1'b0;
                            n_out       = '0;
                        end
                    end
                    fpt_pkg::OP_REMOVE: begin
                        if (slot.board == r_req.board && slot.code == r_req.code) begin
                            n_valid[r_idx] = 1'b0;
                            n_state        = S_IDLE;
                            n_out_valid    = 1'b1;
                            n_out_ok       = 1'b1;
                            n_out          = '0;
                        end else if (last) begin
                            n_state     = S_IDLE;
                            n_out_valid = 1'b1;
                            n_out_ok    = 1'b0;
                            n_out       = '0;
                        end
                    end
                    fpt_pkg::OP_PEEK: begin
                        if (slot.code != '0 && slot.level < r_best_lvl) begin
                            n_best     = slot;
                            n_found    = 1'b1;
                            n_best_lvl = slot.level;
                        end
                        if (last) begin
                            n_state     = S_IDLE;
                            n_out_valid = 1'b1;
                            n_out_ok    = n_found;
                            n_out       = n_best;
                        end
                    end
                    default: begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        n_out_ok    = 1'b0;
                        n_out       = '0;
                    end
                endcase
                if (n_state == S_IDLE) begin
                    n_idx = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= i_operation;
            r_req.board <= i_board_id;
            r_req.code  <= i_error_code;
            r_req.level <= i_level;
        end
        r_best     <= n_best;
        r_found    <= n_found;
        r_best_lvl <= n_best_lvl;
        r_out_ok   <= n_out_ok;
        r_out      <= n_out;
    end

    assign o_valid          = r_out_valid;
    assign o_ok             = r_out_ok;
    assign o_top_board_id   = r_out.board;
    assign o_top_error_code = r_out.code;
    assign o_top_level      = r_out.level;

    // a result only follows an accepted request or a running scan
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy || start))
        else $error("result without request");

    // every finished scan produces a result
    a_scan_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("scan ended without result");

    // a reported entry is never an empty slot and never the excluded level
    a_peek_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_top_error_code != '0) |-> (o_ok && o_top_level != fpt_pkg::NEVER_LEVEL))
        else $error("bad peek result");

    // a failed request reports all zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_top_board_id == '0 && o_top_error_code == '0
                                && o_top_level == '0))
        else $error("failed request with nonzero fields");

endmodule
